@@ hdl/nearest_neighbor_image_scaler_top_assert.svh @@
// Assertion macros for the nearest-neighbor scaler top level.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NNIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/nnis_pkg.sv @@
// Shared types, constants and register codes for the nearest-neighbor scaler.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package nnis_pkg;

  localparam int MAX_DIM_DEF    = 64;
  localparam int PIXEL_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int PIX_W   = 32;  // pixel word on the channels
  localparam int DIM_W   = 16;  // factor, scaled sizes and positions
  localparam int SRC_W   = 7;   // source size registers
  localparam int ADDR_W  = 5;   // register byte address
  localparam int DATA_W  = 32;
  localparam int REGI_W  = 3;

  localparam logic [REGI_W-1:0] REG_SRC_WIDTH     = 3'd0;
  localparam logic [REGI_W-1:0] REG_SRC_HEIGHT    = 3'd1;
  localparam logic [REGI_W-1:0] REG_SCALE_FACTOR  = 3'd2;
  localparam logic [REGI_W-1:0] REG_FIT_MODE      = 3'd3;
  localparam logic [REGI_W-1:0] REG_TARGET_WIDTH  = 3'd4;
  localparam logic [REGI_W-1:0] REG_TARGET_HEIGHT = 3'd5;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [DIM_W-1:0] FACTOR_ONE = 16'd256;
  localparam logic [DIM_W-1:0] DIM_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [SRC_W-1:0] src_width;
    logic [SRC_W-1:0] src_height;
    logic [DIM_W-1:0] scale_factor;
    logic             fit_mode;
    logic [DIM_W-1:0] target_width;
    logic [DIM_W-1:0] target_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    src_width:     7'd64,
    src_height:    7'd64,
    scale_factor:  16'd256,
    fit_mode:      1'b0,
    target_width:  16'd64,
    target_height: 16'd64
  };

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT_W,
    ST_FIT_H,
    ST_SIZE_W,
    ST_SIZE_H,
    ST_MAP_X,
    ST_MAP_Y,
    ST_ADDR,
    ST_OUT
  } seq_state_t;

endpackage

`default_nettype wire

@@ hdl/nnis_in_if.sv @@
// Input channel of the scaler: valid/ready handshake with operation and pixel word.
// Depends on nnis_pkg for the pixel width.
`default_nettype none

interface nnis_in_if import nnis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output operation, output pixel_in, input ready);
  modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

`default_nettype wire

@@ hdl/nnis_out_if.sv @@
// Result channel of the scaler: valid/ready handshake with the scaled pixel fields.
// Depends on nnis_pkg for the field widths.
`default_nettype none

interface nnis_out_if import nnis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [DIM_W-1:0] dest_x;
  logic [DIM_W-1:0] dest_y;
  logic [DIM_W-1:0] dest_width;
  logic [DIM_W-1:0] dest_height;
  logic             last_pixel;

  modport source (output valid, output pixel_out, output dest_x, output dest_y,
                  output dest_width, output dest_height, output last_pixel,
                  input ready);
  modport sink   (input valid, input pixel_out, input dest_x, input dest_y,
                  input dest_width, input dest_height, input last_pixel,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/nnis_regs.sv @@
// APB-style configuration registers of the scaler.
// Depends on nnis_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module nnis_regs import nnis_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t              cfg_r, cfg_nxt;
  logic              wr_fire;
  logic [REGI_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_fire = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_fire) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:     cfg_nxt.src_width     = pwdata[SRC_W-1:0];
        REG_SRC_HEIGHT:    cfg_nxt.src_height    = pwdata[SRC_W-1:0];
        REG_SCALE_FACTOR:  cfg_nxt.scale_factor  = pwdata[DIM_W-1:0];
        REG_FIT_MODE:      cfg_nxt.fit_mode      = pwdata[0];
        REG_TARGET_WIDTH:  cfg_nxt.target_width  = pwdata[DIM_W-1:0];
        REG_TARGET_HEIGHT: cfg_nxt.target_height = pwdata[DIM_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SRC_WIDTH:     prdata = DATA_W'(cfg_r.src_width);
      REG_SRC_HEIGHT:    prdata = DATA_W'(cfg_r.src_height);
      REG_SCALE_FACTOR:  prdata = DATA_W'(cfg_r.scale_factor);
      REG_FIT_MODE:      prdata = DATA_W'(cfg_r.fit_mode);
      REG_TARGET_WIDTH:  prdata = DATA_W'(cfg_r.target_width);
      REG_TARGET_HEIGHT: prdata = DATA_W'(cfg_r.target_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nnis_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on nnis_pkg for the div_stat_t status bundle.
`default_nettype none

module nnis_div import nnis_pkg::*; #(
  parameter int NUM_W = DIM_W + FRAC_BITS_DEF,
  parameter int DEN_W = DIM_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output div_stat_t             stat,
  output logic      [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  // The quotient register shifts the dividend out at the top while the
  // quotient bits enter at the bottom.
  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/nnis_store.sv @@
// Frame store of the scaler: one write port and one registered read port.
// Depends on nnis_pkg for the default depth and pixel width.
`default_nettype none

module nnis_store import nnis_pkg::*; #(
  parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
  parameter int PW    = PIXEL_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [PW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [PW-1:0] rd_data
);

  logic [PW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/nnis_seq.sv @@
// Sequencer of the scaler: loads the frame store, latches the geometry and
// maps each output position through the shared divider. Depends on nnis_pkg.
`default_nettype none

module nnis_seq import nnis_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW    = $clog2(DEPTH),
  localparam int NW    = DIM_W + FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic                  in_valid,
  input  wire logic                  in_operation,
  input  wire logic [PIX_W-1:0]      in_pixel,
  output logic                       in_ready,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic      [PIX_W-1:0]      out_pixel,
  output logic      [DIM_W-1:0]      out_dest_x,
  output logic      [DIM_W-1:0]      out_dest_y,
  output logic      [DIM_W-1:0]      out_dest_width,
  output logic      [DIM_W-1:0]      out_dest_height,
  output logic                       out_last,
  output logic                       div_start,
  output logic      [NW-1:0]         div_dividend,
  output logic      [DIM_W-1:0]      div_divisor,
  input  wire div_stat_t             div_stat,
  input  wire logic [NW-1:0]         div_quotient,
  output logic                       mem_wr_en,
  output logic      [AW-1:0]         mem_wr_addr,
  output logic      [PIXEL_BITS-1:0] mem_wr_data,
  output logic                       mem_rd_en,
  output logic      [AW-1:0]         mem_rd_addr,
  input  wire logic [PIXEL_BITS-1:0] mem_rd_data
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int XW = $clog2(MAX_DIM);
  localparam int TW = AW + 1;
  localparam int PW = DW + DIM_W;

  seq_state_t       state_r, state_nxt;
  logic [AW-1:0]    load_count_r, load_count_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] factor_r, factor_nxt;
  logic [DIM_W-1:0] scaled_w_r, scaled_w_nxt;
  logic [DIM_W-1:0] scaled_h_r, scaled_h_nxt;
  logic [NW-1:0]    fw_r, fw_nxt;
  logic [XW-1:0]    sx_r, sx_nxt;
  logic [XW-1:0]    sy_r, sy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pixel_r, out_pixel_nxt;
  logic [DIM_W-1:0] out_x_r, out_x_nxt;
  logic [DIM_W-1:0] out_y_r, out_y_nxt;
  logic [DIM_W-1:0] out_w_r, out_w_nxt;
  logic [DIM_W-1:0] out_h_r, out_h_nxt;
  logic             out_last_r, out_last_nxt;

  logic [DW-1:0]    sw, sh;
  logic [TW-1:0]    total;
  logic [AW-1:0]    load_idx;
  logic [TW-1:0]    load_inc;
  logic             store_go;
  logic             fetch_go;
  logic [DW-1:0]    size_dim;
  logic [PW-1:0]    size_prod;
  logic [PW-1:0]    size_shift;
  logic [DIM_W-1:0] size_sat;
  logic [NW-1:0]    f_min;
  logic [DIM_W-1:0] fit_sat;
  logic [DW-1:0]    map_lim;
  logic [XW-1:0]    map_clamp;
  logic [DIM_W:0]   col_inc, row_inc;
  logic             row_end, last_hit;
  logic             out_free;
  logic             div_state;

  // A source size above the store limit acts as the limit.
  assign sw = (32'(cfg.src_width) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg.src_width);
  assign sh = (32'(cfg.src_height) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg.src_height);

  assign total    = TW'(sw) * TW'(sh);
  assign load_idx = (TW'(load_count_r) >= total) ? '0 : load_count_r;
  assign load_inc = TW'(load_idx) + TW'(1);
  assign store_go = (state_r == ST_IDLE) && in_valid && (in_operation == OP_STORE);
  assign fetch_go = (state_r == ST_IDLE) && in_valid && (in_operation == OP_FETCH);

  assign size_dim   = (state_r == ST_SIZE_W) ? sw : sh;
  assign size_prod  = PW'(size_dim) * PW'(factor_r);
  assign size_shift = size_prod >> FRAC_BITS;
  assign size_sat   = (size_shift > PW'(DIM_MAX)) ? DIM_MAX : size_shift[DIM_W-1:0];

  assign f_min   = (fw_r < div_quotient) ? fw_r : div_quotient;
  assign fit_sat = (f_min > NW'(DIM_MAX)) ? DIM_MAX : f_min[DIM_W-1:0];

  // A source dimension of zero maps every position to zero.
  assign map_lim   = (state_r == ST_MAP_X) ? sw : sh;
  assign map_clamp = (map_lim == '0)                 ? '0 :
                     (div_quotient >= NW'(map_lim)) ? XW'(map_lim - DW'(1)) :
                                                      XW'(div_quotient);

  assign col_inc  = {1'b0, col_r} + 17'd1;
  assign row_inc  = {1'b0, row_r} + 17'd1;
  assign row_end  = row_inc >= {1'b0, scaled_h_r};
  assign last_hit = row_end && (col_inc >= {1'b0, scaled_w_r});
  assign out_free = !out_valid_r || out_ready;

  assign div_state = (state_r == ST_FIT_W) || (state_r == ST_FIT_H) ||
                     (state_r == ST_MAP_X) || (state_r == ST_MAP_Y);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fetch_go) begin
          if (col_r != '0 || row_r != '0) begin
            state_nxt = ST_MAP_X;
          end else if (sw == '0 || sh == '0 || !cfg.fit_mode) begin
            state_nxt = ST_SIZE_W;
          end else begin
            state_nxt = ST_FIT_W;
          end
        end
      end
      ST_FIT_W:  if (div_stat.done) state_nxt = ST_FIT_H;
      ST_FIT_H:  if (div_stat.done) state_nxt = ST_SIZE_W;
      ST_SIZE_W: state_nxt = ST_SIZE_H;
      ST_SIZE_H: begin
        // An empty scaled image gives no result for this fetch.
        state_nxt = (scaled_w_r == '0 || size_sat == '0) ? ST_IDLE : ST_MAP_X;
      end
      ST_MAP_X:  if (div_stat.done) state_nxt = ST_MAP_Y;
      ST_MAP_Y:  if (div_stat.done) state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and divider operands.
  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    div_start    = div_state && !div_stat.busy && !div_stat.done;
    mem_wr_en    = store_go && (total != '0);
    mem_wr_addr  = load_idx;
    mem_wr_data  = PIXEL_BITS'(in_pixel);
    mem_rd_en    = (state_r == ST_ADDR);
    mem_rd_addr  = AW'(TW'(sx_r) * TW'(sh) + TW'(sy_r));
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_r)
      ST_FIT_W: begin
        div_dividend = {cfg.target_width, {FRAC_BITS{1'b0}}};
        div_divisor  = DIM_W'(sw);
      end
      ST_FIT_H: begin
        div_dividend = {cfg.target_height, {FRAC_BITS{1'b0}}};
        div_divisor  = DIM_W'(sh);
      end
      ST_MAP_X: begin
        div_dividend = {col_r, {FRAC_BITS{1'b0}}};
        div_divisor  = factor_r;
      end
      ST_MAP_Y: begin
        div_dividend = {row_r, {FRAC_BITS{1'b0}}};
        div_divisor  = factor_r;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  // Datapath updates.
  always_comb begin
    load_count_nxt = load_count_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    factor_nxt     = factor_r;
    scaled_w_nxt   = scaled_w_r;
    scaled_h_nxt   = scaled_h_r;
    fw_nxt         = fw_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    out_pixel_nxt  = out_pixel_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_w_nxt      = out_w_r;
    out_h_nxt      = out_h_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;

    if (store_go && total != '0) begin
      load_count_nxt = (load_inc >= total) ? '0 : load_inc[AW-1:0];
      col_nxt        = '0;
      row_nxt        = '0;
    end

    // A fetch at the first position latches the factor for the whole image.
    if (fetch_go && col_r == '0 && row_r == '0) begin
      if (sw == '0 || sh == '0) begin
        factor_nxt = '0;
      end else if (!cfg.fit_mode) begin
        factor_nxt = cfg.scale_factor;
      end
    end

    if (div_stat.done) begin
      unique case (state_r)
        ST_FIT_W: fw_nxt = div_quotient;
        ST_FIT_H: factor_nxt = fit_sat;
        ST_MAP_X: sx_nxt = map_clamp;
        ST_MAP_Y: sy_nxt = map_clamp;
        default:  fw_nxt = fw_r;
      endcase
    end

    if (state_r == ST_SIZE_W) begin
      scaled_w_nxt = size_sat;
    end
    if (state_r == ST_SIZE_H) begin
      scaled_h_nxt = size_sat;
    end

    if (state_r == ST_OUT && out_free) begin
      out_valid_nxt = 1'b1;
      out_pixel_nxt = PIX_W'(mem_rd_data);
      out_x_nxt     = col_r;
      out_y_nxt     = row_r;
      out_w_nxt     = scaled_w_r;
      out_h_nxt     = scaled_h_r;
      out_last_nxt  = last_hit;
      if (last_hit) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        row_nxt = '0;
        col_nxt = col_inc[DIM_W-1:0];
      end else begin
        row_nxt = row_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_count_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
      factor_r     <= FACTOR_ONE;
      scaled_w_r   <= '0;
      scaled_h_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      factor_r     <= factor_nxt;
      scaled_w_r   <= scaled_w_nxt;
      scaled_h_r   <= scaled_h_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fw_r        <= fw_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_w_r     <= out_w_nxt;
    out_h_r     <= out_h_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel       = out_pixel_r;
  assign out_dest_x      = out_x_r;
  assign out_dest_y      = out_y_r;
  assign out_dest_width  = out_w_r;
  assign out_dest_height = out_h_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

@@ hdl/nearest_neighbor_image_scaler_top.sv @@
// Nearest-neighbor image scaler, top level.
//
// The input channel (in_ch) carries store and fetch transfers. A store writes
// the next source pixel into the frame store in column-major order. A fetch
// returns the next pixel of the scaled image on the result channel (out_ch),
// also column-major, with its position, the scaled size and a flag on the
// final pixel. A fetch of an empty scaled image gives nothing. Each fetch
// runs two divisions, column and row by the factor, on one shared radix-2
// divider at one quotient bit per cycle. The first fetch of an image adds
// the scaled-size states ST_SIZE_W and ST_SIZE_H and, in fit mode, two more
// divisions. The user must write configuration over the APB-style port only
// while the block is idle; the block itself does not enforce this.
// Reset restores the register defaults and clears the load and fetch positions;
// the frame store keeps undefined contents until written. When the receiver
// stalls, the finished result waits in the output register and the next item
// may be accepted meanwhile; the block stalls only when a second result is ready.
// Depends on nnis_pkg, the channel interfaces and the assertion macro header.
`default_nettype none

`include "nearest_neighbor_image_scaler_top_assert.svh"

module nearest_neighbor_image_scaler_top import nnis_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  nnis_in_if.sink                in_ch,
  nnis_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = DIM_W + FRAC_BITS;

  cfg_t                  cfg;
  div_stat_t             div_stat;
  logic                  div_start;
  logic [NW-1:0]         div_dividend;
  logic [DIM_W-1:0]      div_divisor;
  logic [NW-1:0]         div_quotient;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [PIXEL_BITS-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [PIXEL_BITS-1:0] mem_rd_data;

  nnis_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nnis_div #(
    .NUM_W (NW),
    .DEN_W (DIM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  nnis_store #(
    .DEPTH (DEPTH),
    .PW    (PIXEL_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  nnis_seq #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_ch.valid),
    .in_operation    (in_ch.operation),
    .in_pixel        (in_ch.pixel_in),
    .in_ready        (in_ch.ready),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_pixel       (out_ch.pixel_out),
    .out_dest_x      (out_ch.dest_x),
    .out_dest_y      (out_ch.dest_y),
    .out_dest_width  (out_ch.dest_width),
    .out_dest_height (out_ch.dest_height),
    .out_last        (out_ch.last_pixel),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_stat        (div_stat),
    .div_quotient    (div_quotient),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data)
  );

  `NNIS_ASSERT_NOW(a_accept_div_idle, in_ch.valid && in_ch.ready, !div_stat.busy && !div_stat.done, "input transfer while the divider is in use")
  `NNIS_ASSERT_NOW(a_done_after_busy, div_stat.done, $past(div_stat.busy), "divider done without a preceding step")
  `NNIS_ASSERT_NEXT(a_read_then_hold, mem_rd_en, !in_ch.ready, "input ready right after a frame store read")

endmodule

`default_nettype wire

@@ tb/nearest_neighbor_image_scaler_top_tb.sv @@
// Self-checking testbench for the nearest-neighbor image scaler top level.
// Predicts every scaled pixel from its own copy of the registers and frame store.
// Depends on nnis_pkg, nnis_in_if, nnis_out_if and the scaler RTL.
module nearest_neighbor_image_scaler_top_tb import nnis_pkg::*; ();

  localparam int DRAIN_CYCLES = 150;
  localparam int STORE_WORDS  = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int FILL_ROWS    = 16;
  localparam int FILL_WORDS   = MAX_DIM_DEF * FILL_ROWS;
  localparam logic [REGI_W-1:0] REG_LIST [6] = '{REG_SRC_WIDTH, REG_SRC_HEIGHT,
      REG_SCALE_FACTOR, REG_FIT_MODE, REG_TARGET_WIDTH, REG_TARGET_HEIGHT};

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             last;
  } scaled_pixel_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  nnis_in_if  in_ch ();
  nnis_out_if out_ch ();

  nearest_neighbor_image_scaler_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: register copy, frame store and the fetch walk.
  cfg_t             regs;
  logic [PIX_W-1:0] frame_mem [STORE_WORDS];
  int unsigned      load_pos;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      factor_latched;
  int unsigned      width_latched;
  int unsigned      height_latched;

  scaled_pixel_t pending_pixels [$];
  int            mismatches     = 0;
  int            items_accepted = 0;
  int            in_gap_pct     = 9;
  int            out_stall_pct  = 51;

  function automatic int unsigned clamp_dim(input logic [SRC_W-1:0] d);
    return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
  endfunction

  function automatic int unsigned sat16(input longint unsigned v);
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  function automatic void scaled_geometry(input cfg_t c, output int unsigned f,
                                          output int unsigned w, output int unsigned h);
    int unsigned     sw;
    int unsigned     sh;
    longint unsigned fw;
    longint unsigned fh;
    longint unsigned raw;
    sw = clamp_dim(c.src_width);
    sh = clamp_dim(c.src_height);
    if (sw == 0 || sh == 0) begin
      raw = 0;
    end else if (c.fit_mode) begin
      fw  = (longint'(c.target_width) << FRAC_BITS_DEF) / sw;
      fh  = (longint'(c.target_height) << FRAC_BITS_DEF) / sh;
      raw = (fw < fh) ? fw : fh;
    end else begin
      raw = longint'(c.scale_factor);
    end
    f = sat16(raw);
    w = sat16((longint'(sw) * f) >> FRAC_BITS_DEF);
    h = sat16((longint'(sh) * f) >> FRAC_BITS_DEF);
  endfunction

  function automatic int unsigned source_coord(input int unsigned d, input int unsigned limit);
    longint unsigned s;
    if (factor_latched == 0 || limit == 0) return 0;
    s = (longint'(d) << FRAC_BITS_DEF) / factor_latched;
    return (s >= limit) ? limit - 1 : int'(s);
  endfunction

  function automatic void predict_scaled_pixel(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned   sw;
    int unsigned   sh;
    int unsigned   total;
    int unsigned   slot;
    scaled_pixel_t p;
    sw = clamp_dim(regs.src_width);
    sh = clamp_dim(regs.src_height);
    if (op == OP_STORE) begin
      total = sw * sh;
      if (total == 0) return;
      slot = (load_pos >= total) ? 0 : load_pos;
      frame_mem[slot] = pix;
      slot++;
      load_pos = (slot >= total) ? 0 : slot;
      col_pos  = 0;
      row_pos  = 0;
      return;
    end
    // The factor and the scaled size are taken only at the start of an image.
    if (col_pos == 0 && row_pos == 0)
      scaled_geometry(regs, factor_latched, width_latched, height_latched);
    if (width_latched == 0 || height_latched == 0) return;
    p.pixel  = frame_mem[source_coord(col_pos, sw) * sh + source_coord(row_pos, sh)];
    p.x      = col_pos[DIM_W-1:0];
    p.y      = row_pos[DIM_W-1:0];
    p.width  = width_latched[DIM_W-1:0];
    p.height = height_latched[DIM_W-1:0];
    p.last   = (col_pos + 1 >= width_latched) && (row_pos + 1 >= height_latched);
    pending_pixels.push_back(p);
    if (p.last) begin
      col_pos = 0;
      row_pos = 0;
    end else if (row_pos + 1 >= height_latched) begin
      row_pos = 0;
      col_pos++;
    end else begin
      row_pos++;
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic string describe(input scaled_pixel_t p);
    return $sformatf("data=%h x=%0d y=%0d w=%0d h=%0d last=%b",
                     p.pixel, p.x, p.y, p.width, p.height, p.last);
  endfunction

  function automatic logic [DATA_W-1:0] reg_mask(input logic [REGI_W-1:0] idx);
    case (idx)
      REG_SRC_WIDTH, REG_SRC_HEIGHT: return 32'h7F;
      REG_FIT_MODE:                  return 32'h1;
      default:                       return 32'hFFFF;
    endcase
  endfunction

  // One transfer on the input channel; valid stays high into the next item.
  task automatic send_op(input logic op, input logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.pixel_in  <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_scaled_pixel(op, pix);
    items_accepted++;
  endtask

  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // A fetch of an empty image leaves no result, so give the sequencer time to finish.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [REGI_W-1:0] idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] ignored;
    apb_transfer(1'b1, idx, value, ignored);
    case (idx)
      REG_SRC_WIDTH:     regs.src_width     = value[SRC_W-1:0];
      REG_SRC_HEIGHT:    regs.src_height    = value[SRC_W-1:0];
      REG_SCALE_FACTOR:  regs.scale_factor  = value[DIM_W-1:0];
      REG_FIT_MODE:      regs.fit_mode      = value[0];
      REG_TARGET_WIDTH:  regs.target_width  = value[DIM_W-1:0];
      REG_TARGET_HEIGHT: regs.target_height = value[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned f, input logic fit,
                              input int unsigned tw, input int unsigned th);
    wait_until_drained();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_SCALE_FACTOR, f);
    write_reg(REG_FIT_MODE, DATA_W'(fit));
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
  endtask

  // The leading part of the frame store is written once, and every later scene
  // keeps its source size small enough that its reads stay inside that part.
  task automatic test_fill_frame_store();
    repeat (FILL_WORDS) send_op(OP_STORE, $urandom());
    repeat (3) send_op(OP_FETCH, $urandom());
  endtask

  task automatic test_register_access();
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] value;
    wait_until_drained();
    foreach (REG_LIST[i]) begin
      for (int k = 0; k < 2; k++) begin
        value = (k == 0) ? '0 : '1;
        write_reg(REG_LIST[i], value);
        apb_transfer(1'b0, REG_LIST[i], '0, rd);
        if ((rd & reg_mask(REG_LIST[i])) !== (value & reg_mask(REG_LIST[i])))
          report_mismatch($sformatf("register %0d read %h after writing %h",
                                    REG_LIST[i], rd, value));
      end
    end
  endtask

  task automatic test_pixel_extremes();
    set_geometry(2, 2, int'(FACTOR_ONE), 1'b0, 1, 1);
    send_op(OP_STORE, 32'h0000_0000);
    send_op(OP_STORE, 32'hFFFF_FFFF);
    send_op(OP_STORE, 32'h5555_5555);
    send_op(OP_STORE, 32'hAAAA_AAAA);
    // Four pixels make the image; the fifth fetch starts it over.
    repeat (5) send_op(OP_FETCH, $urandom());
  endtask

  task automatic test_fit_mode();
    set_geometry(2, 2, int'(FACTOR_ONE), 1'b1, 3, 5);
    send_op(OP_STORE, $urandom());
    repeat (2) send_op(OP_FETCH, $urandom());
    // A one-pixel source against the largest target saturates the factor.
    set_geometry(1, 1, int'(FACTOR_ONE), 1'b1, int'(DIM_MAX), int'(DIM_MAX));
    send_op(OP_STORE, $urandom());
    repeat (2) send_op(OP_FETCH, $urandom());
  endtask

  task automatic test_source_limits();
    set_geometry(3, 3, int'(FACTOR_ONE), 1'b0, 1, 1);
    send_op(OP_STORE, $urandom());
    set_geometry(0, 3, int'(FACTOR_ONE), 1'b0, 1, 1);
    send_op(OP_STORE, $urandom());
    send_op(OP_FETCH, $urandom());
    // A width above the maximum acts as the maximum.
    set_geometry(127, 2, 128, 1'b0, 1, 1);
    repeat (2) send_op(OP_FETCH, $urandom());
  endtask

  task automatic test_latching();
    set_geometry(2, 2, 512, 1'b0, 64, 64);
    send_op(OP_STORE, $urandom());
    repeat (2) send_op(OP_FETCH, $urandom());
    wait_until_drained();
    write_reg(REG_SCALE_FACTOR, DATA_W'(FACTOR_ONE));
    repeat (2) send_op(OP_FETCH, $urandom());
  endtask

  task automatic test_empty_image();
    set_geometry(1, 1, 0, 1'b0, 1, 1);
    send_op(OP_STORE, $urandom());
    send_op(OP_FETCH, $urandom());
    wait_until_drained();
    write_reg(REG_SCALE_FACTOR, 100);
    send_op(OP_FETCH, $urandom());
  endtask

  task automatic test_store_wrap();
    set_geometry(3, 3, int'(FACTOR_ONE), 1'b0, 1, 1);
    repeat (2) send_op(OP_STORE, $urandom());
    // The load position now lies beyond the shrunken source and restarts at zero.
    set_geometry(1, 1, int'(FACTOR_ONE), 1'b0, 1, 1);
    send_op(OP_STORE, $urandom());
    repeat (2) send_op(OP_FETCH, $urandom());
  endtask

  task automatic random_scene();
    int unsigned sw;
    int unsigned sh;
    int unsigned f;
    int unsigned tw;
    int unsigned th;
    int unsigned gf;
    int unsigned gw;
    int unsigned gh;
    int unsigned area;
    int unsigned total;
    int unsigned n_store;
    int unsigned n_fetch;
    logic        fit;
    sw  = $urandom_range(1, 6);
    sh  = $urandom_range(1, 6);
    f   = $urandom_range(64, 700);
    tw  = $urandom_range(1, 20);
    th  = $urandom_range(1, 20);
    fit = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 15))
      0: sw = $urandom_range(0, 127);
      1: sh = $urandom_range(0, 127);
      2: f = $urandom_range(0, 65535);
      3: begin
        fit = 1'b1;
        tw  = $urandom_range(0, 65535);
        th  = $urandom_range(0, 65535);
      end
      4: f = $urandom_range(0, 1) ? 65535 : 0;
      5: begin
        sw = MAX_DIM_DEF;
        sh = FILL_ROWS;
        f  = $urandom_range(1, 64);
      end
      default: ;
    endcase
    set_geometry(sw, sh, f, fit, tw, th);
    scaled_geometry(regs, gf, gw, gh);
    area  = gw * gh;
    total = clamp_dim(regs.src_width) * clamp_dim(regs.src_height);
    n_store = (total <= 64 && $urandom_range(0, 3) != 0) ? total : $urandom_range(0, 3);
    repeat (n_store) send_op(OP_STORE, $urandom());
    if (area == 0)
      n_fetch = $urandom_range(1, 2);
    else if (area <= 24)
      n_fetch = area + $urandom_range(0, area);
    else
      n_fetch = $urandom_range(1, 24);
    repeat (n_fetch) begin
      if ($urandom_range(0, 29) == 0) send_op(OP_STORE, $urandom());
      send_op(OP_FETCH, $urandom());
    end
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int budget);
    int stop_at;
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    stop_at       = items_accepted + budget;
    while (items_accepted < stop_at) random_scene();
  endtask

  initial begin : result_checker
    scaled_pixel_t got;
    scaled_pixel_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.pixel  = out_ch.pixel_out;
        got.x      = out_ch.dest_x;
        got.y      = out_ch.dest_y;
        got.width  = out_ch.dest_width;
        got.height = out_ch.dest_height;
        got.last   = out_ch.last_pixel;
        if (pending_pixels.size() == 0) begin
          report_mismatch({"unexpected result ", describe(got)});
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want)
            report_mismatch({"expected ", describe(want), ", got ", describe(got)});
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  initial begin
    #36_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    regs           = CFG_RESET;
    load_pos       = 0;
    col_pos        = 0;
    row_pos        = 0;
    factor_latched = FACTOR_ONE;
    width_latched  = 0;
    height_latched = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_STORE;
    in_ch.pixel_in  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_fill_frame_store();
    test_register_access();
    test_pixel_extremes();
    test_fit_mode();
    test_source_limits();
    test_latching();
    test_empty_image();
    test_store_wrap();
    test_random_traffic(9, 51, 320);
    test_random_traffic(51, 9, 320);
    test_random_traffic(0, 0, 320);
    wait_until_drained();

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
